@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define CBQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside of reset.
`define CBQ_ASSERT_NEVER(lbl, cond, msg) \
  `CBQ_ASSERT(lbl, !(cond), msg)

`endif

@@ hw/rtl/cbq_pkg.sv @@
package cbq_pkg;

  // Coefficient and gain formats
  localparam int COEF_W     = 16;
  localparam int GAIN_W     = 16;
  localparam int NUM_COEF   = 4;
  localparam int COEF_REG_W = COEF_W * NUM_COEF;
  localparam int COEF_FRAC  = 14;
  localparam int GAIN_FRAC  = 12;
  localparam int CFG_IDX_W  = 2;

  // Gain reset value: 1.0 in Q3.12
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN = 2'd0,
    CFG_SEC0 = 2'd1,
    CFG_SEC1 = 2'd2
  } cfg_idx_e;

  // Lane sequencer states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_SCALE = 5'b00100,
    ST_W     = 5'b01000,
    ST_Y     = 5'b10000
  } lane_state_e;

  // Lane status toward the top level and the merge stage
  typedef struct packed {
    logic ready;
    logic done;
  } lane_stat_t;

endpackage

@@ hw/rtl/cbq_lane.sv @@
module cbq_lane
  import cbq_pkg::*;
#(
  parameter int SW = 16,
  parameter int DW = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [SW-1:0]         sample_i,
  input  logic [GAIN_W-1:0]     gain_i,
  input  logic [COEF_REG_W-1:0] coef0_i,
  input  logic [COEF_REG_W-1:0] coef1_i,
  input  logic                  hold_i,
  output lane_stat_t            stat_o,
  output logic [SW-1:0]         result_o
);

  localparam int LW  = ((SW > DW) ? SW : DW) + 18;
  localparam int PW  = DW + COEF_W;
  localparam int GPW = SW + GAIN_W;

  // Round half up by s bits
  function automatic logic signed [LW-1:0] rnd(input logic signed [LW-1:0] v, input int s);
    logic signed [LW-1:0] half;
    logic signed [LW-1:0] sum;
    half = LW'(1) << (s - 1);
    sum  = v + half;
    return sum >>> s;
  endfunction

  // Saturate to the delay word width
  function automatic logic [DW-1:0] sat_dw(input logic signed [LW-1:0] v);
    if ((&v[LW-1:DW-1]) || !(|v[LW-1:DW-1])) begin
      return v[DW-1:0];
    end
    return {v[LW-1], {(DW-1){~v[LW-1]}}};
  endfunction

  // Saturate to the sample width
  function automatic logic [SW-1:0] sat_sw(input logic signed [LW-1:0] v);
    if ((&v[LW-1:SW-1]) || !(|v[LW-1:SW-1])) begin
      return v[SW-1:0];
    end
    return {v[LW-1], {(SW-1){~v[LW-1]}}};
  endfunction

  lane_state_e state_q, state_d;
  logic        sec_q;

  logic signed [SW-1:0]  sample_q;
  logic signed [GPW-1:0] pg_q, pg_d;
  logic signed [DW-1:0]  x_q, w_q;
  logic signed [PW-1:0]  pa1_q, pa2_q, pb1_q, pb2_q;
  logic signed [PW-1:0]  pa1_d, pa2_d, pb1_d, pb2_d;
  logic signed [DW-1:0]  s0d1_q, s0d2_q, s1d1_q, s1d2_q;

  logic                  sel1;
  logic [COEF_REG_W-1:0] coef_sel;
  logic signed [COEF_W-1:0] ca1, ca2, cb1, cb2;
  logic signed [GAIN_W-1:0] gain_s;
  logic signed [DW-1:0]  dly_a, dly_b;

  logic signed [LW-1:0]  pg_ext, x_ext, w_ext, y_ext, w_sum, y_sum;
  logic signed [DW-1:0]  x_new, w_new, y_new;
  logic                  fin;

  // Pick the section whose products are formed next
  assign sel1     = (state_q == ST_Y);
  assign coef_sel = sel1 ? coef1_i : coef0_i;
  assign ca1      = coef_sel[COEF_W-1:0];
  assign ca2      = coef_sel[2*COEF_W-1:COEF_W];
  assign cb1      = coef_sel[3*COEF_W-1:2*COEF_W];
  assign cb2      = coef_sel[4*COEF_W-1:3*COEF_W];
  assign dly_a    = sel1 ? s1d1_q : s0d1_q;
  assign dly_b    = sel1 ? s1d2_q : s0d2_q;
  assign gain_s   = gain_i;

  // Multiply stage
  assign pg_d  = sample_q * gain_s;
  assign pa1_d = ca1 * dly_a;
  assign pa2_d = ca2 * dly_b;
  assign pb1_d = cb1 * dly_a;
  assign pb2_d = cb2 * dly_b;

  // Scale, feedback and feedforward sums
  assign pg_ext = {{(LW-GPW){pg_q[GPW-1]}}, pg_q};
  assign x_new  = sat_dw(rnd(pg_ext, GAIN_FRAC));
  assign x_ext  = {{(LW-DW){x_q[DW-1]}}, x_q};
  assign w_sum  = (x_ext <<< COEF_FRAC) - {{(LW-PW){pb1_q[PW-1]}}, pb1_q}
                  - {{(LW-PW){pb2_q[PW-1]}}, pb2_q};
  assign w_new  = sat_dw(rnd(w_sum, COEF_FRAC));
  assign w_ext  = {{(LW-DW){w_q[DW-1]}}, w_q};
  assign y_sum  = (w_ext <<< COEF_FRAC) + {{(LW-PW){pa1_q[PW-1]}}, pa1_q}
                  + {{(LW-PW){pa2_q[PW-1]}}, pa2_q};
  assign y_new  = sat_dw(rnd(y_sum, COEF_FRAC));
  assign y_ext  = {{(LW-DW){y_new[DW-1]}}, y_new};

  assign fin      = (state_q == ST_Y) && sec_q && !hold_i;
  assign result_o = sat_sw(y_ext);
  assign stat_o.ready = (state_q == ST_IDLE) || fin;
  assign stat_o.done  = fin;

  // Sequence one sample through both sections
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_MUL;
      ST_MUL:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_W;
      ST_W:     state_d = ST_Y;
      ST_Y: begin
        if (!sec_q) begin
          state_d = ST_W;
        end else if (!hold_i) begin
          state_d = start_i ? ST_MUL : ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control state and delay lines
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sec_q   <= 1'b0;
      s0d1_q  <= '0;
      s0d2_q  <= '0;
      s1d1_q  <= '0;
      s1d2_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_Y && !sec_q) begin
        sec_q  <= 1'b1;
        s0d2_q <= s0d1_q;
        s0d1_q <= w_q;
      end
      if (fin) begin
        s1d2_q <= s1d1_q;
        s1d1_q <= w_q;
      end
      if (start_i) begin
        sec_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sample_q <= sample_i;
    end
    if (state_q == ST_MUL || (state_q == ST_Y && !sec_q)) begin
      pa1_q <= pa1_d;
      pa2_q <= pa2_d;
      pb1_q <= pb1_d;
      pb2_q <= pb2_d;
    end
    if (state_q == ST_MUL) begin
      pg_q <= pg_d;
    end
    if (state_q == ST_SCALE) begin
      x_q <= x_new;
    end else if (state_q == ST_Y && !sec_q) begin
      x_q <= y_new;
    end
    if (state_q == ST_W) begin
      w_q <= w_new;
    end
  end

endmodule

@@ hw/rtl/cbq_merge.sv @@
module cbq_merge
  import cbq_pkg::*;
#(
  parameter int SW  = 16,
  parameter int TDW = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lane_stat_t     stat_re_i,
  input  lane_stat_t     stat_im_i,
  input  logic [SW-1:0]  res_re_i,
  input  logic [SW-1:0]  res_im_i,
  input  logic           m_axis_tready,
  output logic           m_axis_tvalid,
  output logic [TDW-1:0] m_axis_tdata,
  output logic           hold_o
);

  logic           valid_q;
  logic [TDW-1:0] data_q;
  logic           both_done;

  assign both_done     = stat_re_i.done && stat_im_i.done;
  assign hold_o        = valid_q && !m_axis_tready;
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (both_done) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  // Pack both parts into one item
  always_ff @(posedge clk_i) begin
    if (both_done) begin
      data_q <= TDW'({res_im_i, res_re_i});
    end
  end

endmodule

@@ hw/rtl/complex_biquad_cascade_filter.sv @@
// Complex two-section direct form II biquad cascade. Each input item is one
// I/Q sample; both parts are scaled by the Q3.12 gain and filtered by two
// biquad sections whose a1, a2, b1, b2 (Q1.14) are shared by the I and Q
// lanes, which run side by side with their own delay lines. One saturated
// I/Q result comes out per item. In a lane an item passes a multiply state,
// a scaling state, then a feedback and a feedforward state per section,
// looping back once for the second section. A new item is taken in the
// cycle the previous one finishes. The output register lets a lane work on
// the next item while a result waits. The user must write configuration
// through cfg_we_i / cfg_idx_i / cfg_data_i only while no item is in
// flight; the block itself does not enforce this.
`include "assert_macros.svh"

module complex_biquad_cascade_filter
  import cbq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int STATE_WIDTH  = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Input stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // tdata: sample_re, sample_im, zero pad
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // Output stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // tdata: out_re, out_im, zero pad
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // Configuration write port
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [COEF_REG_W-1:0]     cfg_data_i
);

  localparam int TDW = ((2*SAMPLE_WIDTH+7)/8)*8;

  logic [GAIN_W-1:0]     gain_q;
  logic [COEF_REG_W-1:0] coef0_q, coef1_q;
  lane_stat_t            stat_re, stat_im;
  logic [SAMPLE_WIDTH-1:0] res_re, res_im;
  logic                  hold;
  logic                  start;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GAIN_RESET;
      coef0_q <= '0;
      coef1_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GAIN: gain_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_SEC0: coef0_q <= cfg_data_i;
        CFG_SEC1: coef1_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  assign s_axis_tready = stat_re.ready;
  assign start         = s_axis_tvalid && s_axis_tready;

  // In-phase lane
  cbq_lane #(
    .SW(SAMPLE_WIDTH),
    .DW(STATE_WIDTH)
  ) u_lane_re (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .sample_i (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .gain_i   (gain_q),
    .coef0_i  (coef0_q),
    .coef1_i  (coef1_q),
    .hold_i   (hold),
    .stat_o   (stat_re),
    .result_o (res_re)
  );

  // Quadrature lane
  cbq_lane #(
    .SW(SAMPLE_WIDTH),
    .DW(STATE_WIDTH)
  ) u_lane_im (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .sample_i (s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .gain_i   (gain_q),
    .coef0_i  (coef0_q),
    .coef1_i  (coef1_q),
    .hold_i   (hold),
    .stat_o   (stat_im),
    .result_o (res_im)
  );

  // Merge lane results into the output register
  cbq_merge #(
    .SW (SAMPLE_WIDTH),
    .TDW(TDW)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stat_re_i     (stat_re),
    .stat_im_i     (stat_im),
    .res_re_i      (res_re),
    .res_im_i      (res_im),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .hold_o        (hold)
  );

  `CBQ_ASSERT(a_lanes_lockstep, stat_re == stat_im, "I and Q lanes out of step")
  `CBQ_ASSERT_NEVER(a_done_into_full, stat_re.done && m_axis_tvalid && !m_axis_tready,
    "lane finished while output register was blocked")
  `CBQ_ASSERT(a_accept_then_busy, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready,
    "lane ready again right after taking an item")

endmodule
